### rtl/core/ordered_timer_queue_top_defines.svh
// assertion macros for the timer queue checker
`ifndef ORDERED_TIMER_QUEUE_TOP_DEFINES_SVH
`define ORDERED_TIMER_QUEUE_TOP_DEFINES_SVH
// property checked on every clock edge outside reset
`define OTQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same-cycle implication checked on every clock edge outside reset
`define OTQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`endif

### rtl/core/otq_pkg.sv
// shared constants and types of the timer queue
package otq_pkg;
  localparam int unsigned Capacity = 16;
  localparam int unsigned SlotW = $clog2(Capacity);
  localparam int unsigned IdW = 32;
  localparam int unsigned TimeW = 63;
  localparam int unsigned IvW = 32;
  localparam logic [TimeW-1:0] MinDelay = TimeW'(100);
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef enum logic [1:0] {
    ActAdd = 2'd0, ActCancel = 2'd1, ActTick = 2'd2, ActNone = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KindAdd = 2'd0, KindCancel = 2'd1, KindExpired = 2'd2, KindNext = 2'd3
  } kind_e;

  localparam int unsigned EntW = IdW + TimeW + IvW;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] deadline;
    logic [IvW-1:0]   interval;
  } entry_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [IdW-1:0]   timer_id;
    logic [TimeW-1:0] deadline;
    logic [IvW-1:0]   repeat_interval;
    logic [TimeW-1:0] now_time;
  } req_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IdW-1:0]   result_id;
    logic             hit;
    logic             table_full;
    logic             earliest_changed;
    logic             next_valid;
    logic [TimeW-1:0] next_deadline;
    logic [TimeW-1:0] next_delay;
    logic             last;
  } rsp_t;

  // strict (deadline, id) order; ties fall to scan order
  function automatic logic key_less(logic [TimeW-1:0] da, logic [IdW-1:0] ia,
                                    logic [TimeW-1:0] db, logic [IdW-1:0] ib);
    key_less = (da < db) || ((da == db) && (ia < ib));
  endfunction
endpackage

### rtl/core/otq_if.sv
// valid/ready channel carrying one payload struct
interface otq_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/otq_ram.sv
// generic single port ram with registered read
module otq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### rtl/core/ordered_timer_queue_top.sv
// timer queue top level: sequencer scanning the entry ram
// Usage of the ordered timer queue.
// Input channel req_if carries action, timer_id, deadline, repeat_interval
// and now_time; output channel rsp_if carries the results of each item.
// An add or cancel gives one result, a tick gives one result per expired
// timer in (deadline, id) order and a closing next-deadline result.
// Items are handled one at a time. A scan pass over the sixteen entries of
// the single-port ram issues one read per cycle; the ram read is registered.
// Add and cancel give their result after a scan pass. A tick runs a
// search pass and an emit per expired timer, then a final minimum pass
// before the closing result.
// Valid bits live in flip-flops, cleared by reset together with the id
// counter (reset to one); no clearing pass is needed.
// When the receiver stalls, scanning goes on but the next emit or closing
// result waits on the held one; a new item is taken only once the current
// one has produced its last result.
module ordered_timer_queue_top
  import otq_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  otq_if.sink   req_if,
  otq_if.source rsp_if
);
  typedef enum logic [2:0] {
    StIdle, StScan, StEmit, StFinal, StWait
  } state_e;

  state_e            state_q;
  req_t              req_q;
  logic [Capacity-1:0] valid_q;
  logic [IdW-1:0]    next_id_q;
  logic [SlotW:0]    cnt_q;     // issue counter
  logic              rd_q;      // read data valid this cycle
  logic [SlotW-1:0]  rslot_q;
  // scan results
  logic              found_q;
  logic [SlotW-1:0]  bslot_q;
  logic [TimeW-1:0]  bdl_q;
  logic [IdW-1:0]    bid_q;
  logic [IvW-1:0]    biv_q;
  logic              early_q;
  logic              phase_q;   // tick: 0 expiry search, 1 final minimum
  logic [Capacity-1:0] done_q;  // tick: expired entries already emitted
  rsp_t              rsp_q;
  logic              rsp_v_q;

  logic              we;
  logic [SlotW-1:0]  addr;
  entry_t            wdata, rdata;

  otq_ram #(.Width(EntW), .Depth(Capacity)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  logic [SlotW-1:0] free_slot;
  logic             any_free;
  always_comb begin
    free_slot = '0;
    any_free = 1'b0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = SlotW'(i);
        any_free = 1'b1;
      end
    end
  end

  logic [TimeW:0] rearm_sum;
  assign rearm_sum = {1'b0, req_q.now_time} + {{(TimeW+1-IvW){1'b0}}, biv_q};

  logic [TimeW-1:0] diff;
  assign diff = bdl_q - req_q.now_time;

  logic scan_end;
  assign scan_end = (cnt_q == (SlotW+1)'(Capacity));

  // ram port: writes in emit or add finish, otherwise scan reads
  always_comb begin
    we = 1'b0;
    addr = cnt_q[SlotW-1:0];
    wdata = entry_t'{id: next_id_q, deadline: req_q.deadline,
                     interval: req_q.repeat_interval};
    if (state_q == StEmit && !rsp_v_q) begin
      we = 1'b1;
      addr = bslot_q;
      wdata = entry_t'{id: bid_q,
                       deadline: rearm_sum[TimeW] ? TimeMax : rearm_sum[TimeW-1:0],
                       interval: biv_q};
    end else if (state_q == StFinal && req_q.action == ActAdd && any_free) begin
      we = 1'b1;
      addr = free_slot;
    end
  end

  // result items of the emit and final states
  rsp_t exp_rsp, fin_rsp;
  always_comb begin
    exp_rsp = '0;
    exp_rsp.kind = KindExpired;
    exp_rsp.result_id = bid_q;
    fin_rsp = '0;
    fin_rsp.last = 1'b1;
    case (req_q.action)
      ActAdd: begin
        fin_rsp.kind = KindAdd;
        if (any_free) begin
          fin_rsp.result_id = next_id_q;
          fin_rsp.hit = 1'b1;
          fin_rsp.earliest_changed = early_q;
        end else begin
          fin_rsp.table_full = 1'b1;
        end
      end
      ActCancel: begin
        fin_rsp.kind = KindCancel;
        fin_rsp.result_id = req_q.timer_id;
        fin_rsp.hit = found_q;
      end
      default: begin
        fin_rsp.kind = KindNext;
        fin_rsp.next_valid = found_q;
        fin_rsp.next_deadline = found_q ? bdl_q : '0;
        fin_rsp.next_delay = (found_q && bdl_q > req_q.now_time &&
                              diff > MinDelay) ? diff : MinDelay;
      end
    endcase
  end

  assign req_if.ready = (state_q == StIdle);
  assign rsp_if.valid = rsp_v_q;
  assign rsp_if.data = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= '0;
      next_id_q <= IdW'(1);
      rsp_v_q <= 1'b0;
      cnt_q <= '0;
      rd_q <= 1'b0;
      found_q <= 1'b0;
      phase_q <= 1'b0;
      done_q <= '0;
    end else begin
      if (rsp_v_q && rsp_if.ready) begin
        rsp_v_q <= 1'b0;
      end
      // evaluate the entry read in the previous cycle
      if (rd_q && valid_q[rslot_q]) begin
        case (req_q.action)
          ActAdd: begin
            if (rdata.deadline < req_q.deadline ||
                (rdata.deadline == req_q.deadline && rdata.id <= next_id_q)) begin
              early_q <= 1'b0;
            end
          end
          ActCancel: begin
            if (!found_q && rdata.id == req_q.timer_id && req_q.timer_id != '0) begin
              found_q <= 1'b1;
              bslot_q <= rslot_q;
            end
          end
          default: begin
            if ((phase_q || (rdata.deadline <= req_q.now_time && !done_q[rslot_q]))
                && (!found_q || key_less(rdata.deadline, rdata.id, bdl_q, bid_q))) begin
              found_q <= 1'b1;
              bslot_q <= rslot_q;
              bdl_q <= rdata.deadline;
              bid_q <= rdata.id;
              biv_q <= rdata.interval;
            end
          end
        endcase
      end
      rd_q <= (state_q == StScan) && !scan_end;
      case (state_q)
        StIdle: begin
          if (req_if.valid) begin
            req_q <= req_if.data;
            cnt_q <= '0;
            found_q <= 1'b0;
            early_q <= 1'b1;
            phase_q <= 1'b0;
            done_q <= '0;
            if (req_if.data.action != ActNone) begin
              state_q <= StScan;
            end
          end
        end
        StScan: begin
          if (!scan_end) begin
            rslot_q <= cnt_q[SlotW-1:0];
            cnt_q <= cnt_q + 1'b1;
          end else if (!rd_q) begin
            state_q <= (req_q.action == ActTick && !phase_q && found_q) ? StEmit
                                                                         : StFinal;
          end
        end
        StEmit: begin
          // one expired timer: report it and re-arm or drop it
          if (!rsp_v_q) begin
            rsp_q <= exp_rsp;
            rsp_v_q <= 1'b1;
            done_q[bslot_q] <= 1'b1;
            if (biv_q == '0) begin
              valid_q[bslot_q] <= 1'b0;
            end
            found_q <= 1'b0;
            cnt_q <= '0;
            state_q <= StScan;
          end
        end
        StFinal: begin
          if (req_q.action == ActTick && !phase_q) begin
            phase_q <= 1'b1;
            found_q <= 1'b0;
            cnt_q <= '0;
            state_q <= StScan;
          end else if (!rsp_v_q) begin
            rsp_q <= fin_rsp;
            rsp_v_q <= 1'b1;
            state_q <= StWait;
            case (req_q.action)
              ActAdd: begin
                if (any_free) begin
                  valid_q[free_slot] <= 1'b1;
                  next_id_q <= (next_id_q == {IdW{1'b1}}) ? IdW'(1)
                                                          : next_id_q + 1'b1;
                end
              end
              ActCancel: begin
                if (found_q) begin
                  valid_q[bslot_q] <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        StWait: begin
          if (!rsp_v_q || rsp_if.ready) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

### rtl/core/otq_checker.sv
// port level checks of the timer queue, bound to the top level
`include "ordered_timer_queue_top_defines.svh"
module otq_checker
  import otq_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input rsp_t rsp_data_i
);
  // a result waiting is held
  `OTQ_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i), "result dropped")
  // no new item while a result is pending
  `OTQ_ASSERT_IMP(a_no_accept, clk_i, rst_ni, rsp_valid_i, !req_ready_i, "item taken while busy")
  // expired results are never final, others always are
  `OTQ_ASSERT_IMP(a_last, clk_i, rst_ni, rsp_valid_i, rsp_data_i.last == (rsp_data_i.kind != KindExpired), "bad last flag")
  // the next-deadline delay never goes below the floor
  `OTQ_ASSERT_IMP(a_delay, clk_i, rst_ni, rsp_valid_i && rsp_data_i.kind == KindNext, rsp_data_i.next_delay >= MinDelay, "delay below floor")
endmodule

bind ordered_timer_queue_top otq_checker u_otq_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .req_ready_i(req_if.ready),
  .rsp_valid_i(rsp_if.valid), .rsp_ready_i(rsp_if.ready), .rsp_data_i(rsp_if.data)
);
